### rtl/tld_pkg.sv
// Shared constants, types and helper functions of the three-level debounce.
`default_nettype none
package tld_pkg;

	// Level encoding
	typedef logic [1:0] level_t;
	localparam level_t LVL_UNKNOWN = 2'd0;
	localparam level_t LVL_LOW     = 2'd1;
	localparam level_t LVL_MEDIUM  = 2'd2;
	localparam level_t LVL_HIGH    = 2'd3;

	// Parameter defaults
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int TIME_BITS_DEF   = 16;

	// Fixed field widths
	localparam int THR_FIELD_BITS = 12;
	localparam int SLOT_BITS      = 16;
	localparam int TIMES_BITS     = 3 * SLOT_BITS;
	localparam int CODE_BITS      = 8;
	localparam int MAP_BITS       = 3 * CODE_BITS;
	localparam int MODE_BITS      = 2;
	localparam int CFG_DATA_BITS  = TIMES_BITS;
	localparam int CFG_IDX_BITS   = 3;

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_THR_LOW   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_THR_HIGH  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_TICK_UNIT = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_FILT_TIME = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TIME = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_MODE      = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_START_LVL = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAP_CODES = 3'd7;

	// Stage modes
	localparam logic [MODE_BITS-1:0] MODE_CLASSIFY = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_FILTER   = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_HOLD     = 2'd2;

	// Reset values of the registers
	localparam logic [THR_FIELD_BITS-1:0] THR_HIGH_RST  = 12'hFFF;
	localparam logic [SLOT_BITS-1:0]      TICK_UNIT_RST = 16'd1;
	localparam logic [MAP_BITS-1:0]       MAP_CODES_RST = 24'd3211521;

	// Level flags of the debounce state
	typedef struct packed {
		level_t cur;
		level_t prev;
		level_t filt;
		level_t hold;
		logic   counting;
	} tld_lvl_t;

	// Time slot of a known level from a packed times register
	function automatic logic [SLOT_BITS-1:0] slot_time(input logic [TIMES_BITS-1:0] times,
			input level_t lvl);
		logic [SLOT_BITS-1:0] t;
		case (lvl)
			LVL_LOW:    t = times[SLOT_BITS-1:0];
			LVL_MEDIUM: t = times[2*SLOT_BITS-1:SLOT_BITS];
			LVL_HIGH:   t = times[3*SLOT_BITS-1:2*SLOT_BITS];
			default:    t = '0;
		endcase
		return t;
	endfunction

	// Mapped code of a level, zero when unknown
	function automatic logic [CODE_BITS-1:0] level_code(input logic [MAP_BITS-1:0] map,
			input level_t lvl);
		logic [CODE_BITS-1:0] c;
		case (lvl)
			LVL_LOW:    c = map[CODE_BITS-1:0];
			LVL_MEDIUM: c = map[2*CODE_BITS-1:CODE_BITS];
			LVL_HIGH:   c = map[3*CODE_BITS-1:2*CODE_BITS];
			default:    c = '0;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

### rtl/tld_in_if.sv
// Sample request channel: valid/ready plus one sample and its enable bit.
`default_nettype none
interface tld_in_if #(
	parameter int SAMPLE_BITS = 12
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   active;

	modport source (output valid, output sample, output active, input ready);
	modport sink   (input valid, input sample, input active, output ready);
endinterface
`default_nettype wire

### rtl/tld_out_if.sv
// Result request channel: valid/ready plus the three levels and their codes.
`default_nettype none
interface tld_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] raw_level;
	logic [1:0] filtered_level;
	logic [1:0] held_level;
	logic [7:0] raw_code;
	logic [7:0] filtered_code;
	logic [7:0] held_code;

	modport source (output valid, output raw_level, output filtered_level, output held_level,
		output raw_code, output filtered_code, output held_code, input ready);
	modport sink   (input valid, input raw_level, input filtered_level, input held_level,
		input raw_code, input filtered_code, input held_code, output ready);
endinterface
`default_nettype wire

### rtl/tld_cfg_if.sv
// Configuration write channel: valid/ready plus register index and data.
`default_nettype none
interface tld_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [47:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/tristate_level_debounce_core.sv
// Top level of the three-level threshold debounce with hold.
//
//   channel | dir | handshake     | payload
//   din     | in  | valid / ready | sample, active
//   dout    | out | valid / ready | raw/filtered/held level and code
//   cfg     | in  | valid / ready | index, data (register write)
//
// One sample per clock while the result is not stalled: an accepted sample is
// captured in the input register, its next state and result are worked out
// there and land in the result register, which drives dout.valid. The state
// update is a single add, saturate and compare per counter. Reset clears
// handshake state, loads register defaults and puts all levels of the debounce
// state at unknown. A stalled result holds the input register; a new sample is
// still taken while the result waits alone.
// Configuration writes are always accepted.
`default_nettype none
module tristate_level_debounce_core #(
	parameter int SAMPLE_BITS = tld_pkg::SAMPLE_BITS_DEF,
	parameter int TIME_BITS   = tld_pkg::TIME_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tld_in_if.sink    din,
	tld_out_if.source dout,
	tld_cfg_if.sink   cfg
);
	import tld_pkg::*;

	// Configuration registers
	logic [SAMPLE_BITS-1:0] thr_low_q;
	logic [SAMPLE_BITS-1:0] thr_high_q;
	logic [SLOT_BITS-1:0]   tick_unit_q;
	logic [TIMES_BITS-1:0]  filt_times_q;
	logic [TIMES_BITS-1:0]  hold_times_q;
	logic [MODE_BITS-1:0]   mode_q;
	logic [MAP_BITS-1:0]    map_codes_q;

	// Debounce state
	tld_lvl_t               lvl_q;
	logic [TIME_BITS-1:0]   fcnt_q;
	logic [TIME_BITS-1:0]   hcnt_q;
	tld_lvl_t               lvl_d;
	logic [TIME_BITS-1:0]   fcnt_d;
	logic [TIME_BITS-1:0]   hcnt_d;
	tld_lvl_t               lvl_upd;

	// Input stage
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   active_s1;

	// Result register
	logic                   out_valid_q;
	level_t                 raw_lvl_q;
	level_t                 filt_lvl_q;
	level_t                 hold_lvl_q;
	logic [CODE_BITS-1:0]   raw_code_q;
	logic [CODE_BITS-1:0]   filt_code_q;
	logic [CODE_BITS-1:0]   hold_code_q;

	logic                   advance;
	logic                   in_take;
	logic                   cfg_wr;
	logic                   filt_wr;
	logic                   hold_wr;
	logic                   start_wr;

	assign advance  = valid_s1 && (!out_valid_q || dout.ready);
	assign din.ready = !valid_s1 || advance;
	assign in_take  = din.valid && din.ready;
	assign cfg.ready = 1'b1;
	assign cfg_wr   = cfg.valid;
	assign filt_wr  = cfg_wr && (cfg.index == REG_FILT_TIME);
	assign hold_wr  = cfg_wr && (cfg.index == REG_HOLD_TIME);
	assign start_wr = cfg_wr && (cfg.index == REG_START_LVL);

	// Capture an accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_s1 <= din.sample;
			active_s1 <= din.active;
		end
	end

	tld_step #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.TIME_BITS   (TIME_BITS)
	) u_step (
		.thr_low    (thr_low_q),
		.thr_high   (thr_high_q),
		.tick_unit  (tick_unit_q),
		.filt_times (filt_times_q),
		.hold_times (hold_times_q),
		.mode       (mode_q),
		.active     (active_s1),
		.sample     (sample_s1),
		.lvl_cur    (lvl_q),
		.fcnt_cur   (fcnt_q),
		.hcnt_cur   (hcnt_q),
		.lvl_nxt    (lvl_d),
		.fcnt_nxt   (fcnt_d),
		.hcnt_nxt   (hcnt_d)
	);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_low_q    <= '0;
			thr_high_q   <= SAMPLE_BITS'(THR_HIGH_RST);
			tick_unit_q  <= TICK_UNIT_RST;
			filt_times_q <= '0;
			hold_times_q <= '0;
			mode_q       <= MODE_CLASSIFY;
			map_codes_q  <= MAP_CODES_RST;
		end else if (cfg_wr) begin
			case (cfg.index)
				REG_THR_LOW:   thr_low_q    <= SAMPLE_BITS'(cfg.data[THR_FIELD_BITS-1:0]);
				REG_THR_HIGH:  thr_high_q   <= SAMPLE_BITS'(cfg.data[THR_FIELD_BITS-1:0]);
				REG_TICK_UNIT: tick_unit_q  <= cfg.data[SLOT_BITS-1:0];
				REG_FILT_TIME: filt_times_q <= cfg.data[TIMES_BITS-1:0];
				REG_HOLD_TIME: hold_times_q <= cfg.data[TIMES_BITS-1:0];
				REG_MODE:      mode_q       <= cfg.data[MODE_BITS-1:0];
				REG_MAP_CODES: map_codes_q  <= cfg.data[MAP_BITS-1:0];
				default:       mode_q       <= mode_q;
			endcase
		end
	end

	// Merge the stepped levels with a start level load
	always_comb begin
		lvl_upd = advance ? lvl_d : lvl_q;
		if (start_wr) begin
			lvl_upd.filt = level_t'(cfg.data[1:0]);
			lvl_upd.hold = level_t'(cfg.data[1:0]);
		end
	end

	// Advance debounce state; register writes clear or load it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q  <= '{cur: LVL_UNKNOWN, prev: LVL_UNKNOWN, filt: LVL_UNKNOWN,
				hold: LVL_UNKNOWN, counting: 1'b0};
			fcnt_q <= '0;
			hcnt_q <= '0;
		end else begin
			lvl_q <= lvl_upd;
			if (filt_wr) begin
				fcnt_q <= '0;
			end else if (advance) begin
				fcnt_q <= fcnt_d;
			end
			if (hold_wr) begin
				hcnt_q <= '0;
			end else if (advance) begin
				hcnt_q <= hcnt_d;
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			raw_lvl_q   <= lvl_d.cur;
			filt_lvl_q  <= lvl_d.filt;
			hold_lvl_q  <= lvl_d.hold;
			raw_code_q  <= level_code(map_codes_q, lvl_d.cur);
			filt_code_q <= level_code(map_codes_q, lvl_d.filt);
			hold_code_q <= level_code(map_codes_q, lvl_d.hold);
		end
	end

	assign dout.valid          = out_valid_q;
	assign dout.raw_level      = raw_lvl_q;
	assign dout.filtered_level = filt_lvl_q;
	assign dout.held_level     = hold_lvl_q;
	assign dout.raw_code       = raw_code_q;
	assign dout.filtered_code  = filt_code_q;
	assign dout.held_code      = hold_code_q;

endmodule
`default_nettype wire

### rtl/tld_step.sv
// Next-state logic of one sample: classify, filter and hold.
`default_nettype none
module tld_step #(
	parameter int SAMPLE_BITS = tld_pkg::SAMPLE_BITS_DEF,
	parameter int TIME_BITS   = tld_pkg::TIME_BITS_DEF
) (
	input  wire logic [SAMPLE_BITS-1:0]             thr_low,
	input  wire logic [SAMPLE_BITS-1:0]             thr_high,
	input  wire logic [tld_pkg::SLOT_BITS-1:0]      tick_unit,
	input  wire logic [tld_pkg::TIMES_BITS-1:0]     filt_times,
	input  wire logic [tld_pkg::TIMES_BITS-1:0]     hold_times,
	input  wire logic [tld_pkg::MODE_BITS-1:0]      mode,
	input  wire logic                               active,
	input  wire logic [SAMPLE_BITS-1:0]             sample,
	input  wire tld_pkg::tld_lvl_t                  lvl_cur,
	input  wire logic [TIME_BITS-1:0]               fcnt_cur,
	input  wire logic [TIME_BITS-1:0]               hcnt_cur,
	output tld_pkg::tld_lvl_t                       lvl_nxt,
	output logic [TIME_BITS-1:0]                    fcnt_nxt,
	output logic [TIME_BITS-1:0]                    hcnt_nxt
);
	import tld_pkg::*;

	localparam int SUM_BITS = ((TIME_BITS > SLOT_BITS) ? TIME_BITS : SLOT_BITS) + 1;
	localparam logic [TIME_BITS-1:0] COUNT_MAX = {TIME_BITS{1'b1}};

	level_t              cls;
	logic [SUM_BITS-1:0] fsum;
	logic [SUM_BITS-1:0] hsum;
	logic [TIME_BITS-1:0] fsat;
	logic [TIME_BITS-1:0] hsat;
	logic                filt_on;
	logic                hold_on;

	// Classify against the two thresholds
	always_comb begin
		if (sample >= thr_high) begin
			cls = LVL_HIGH;
		end else if (sample >= thr_low) begin
			cls = LVL_MEDIUM;
		end else begin
			cls = LVL_LOW;
		end
	end

	// Saturating counter sums
	assign fsum = SUM_BITS'(fcnt_cur) + SUM_BITS'(tick_unit);
	assign hsum = SUM_BITS'(hcnt_cur) + SUM_BITS'(tick_unit);
	assign fsat = (fsum > SUM_BITS'(COUNT_MAX)) ? COUNT_MAX : fsum[TIME_BITS-1:0];
	assign hsat = (hsum > SUM_BITS'(COUNT_MAX)) ? COUNT_MAX : hsum[TIME_BITS-1:0];

	assign filt_on = (mode != MODE_CLASSIFY);
	assign hold_on = mode[1];

	// Advance filter, then hold on the freshly filtered level
	always_comb begin
		lvl_nxt  = lvl_cur;
		fcnt_nxt = fcnt_cur;
		hcnt_nxt = hcnt_cur;
		if (active) begin
			lvl_nxt.cur = cls;
			if (filt_on) begin
				if (cls != lvl_cur.prev) begin
					lvl_nxt.prev     = cls;
					fcnt_nxt         = '0;
					lvl_nxt.counting = 1'b1;
				end else if (lvl_cur.counting) begin
					fcnt_nxt = fsat;
					if (SUM_BITS'(fsat) >= SUM_BITS'(slot_time(filt_times, cls))) begin
						lvl_nxt.counting = 1'b0;
						lvl_nxt.filt     = cls;
					end
				end
				if (hold_on) begin
					if (lvl_cur.hold == lvl_nxt.filt) begin
						hcnt_nxt = '0;
					end else if (lvl_cur.hold == LVL_UNKNOWN ||
							SUM_BITS'(hsat) >= SUM_BITS'(slot_time(hold_times, lvl_cur.hold))) begin
						lvl_nxt.hold = lvl_nxt.filt;
						hcnt_nxt     = '0;
					end else begin
						hcnt_nxt = hsat;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire
